>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the integer-to-ASCII converter.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/i2a_pkg.sv
// Shared types, codes and character helpers of the integer-to-ASCII converter.
// No dependencies.
`default_nettype none

package i2a_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned LOW_W   = 32;
    localparam int unsigned NIB_CNT = VALUE_W / 4;
    localparam int unsigned CNT_W   = $clog2(NIB_CNT + 1);

    // Format modes.
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_HEXL = 3'd2;
    localparam logic [2:0] MODE_HEXU = 3'd3;
    localparam logic [2:0] MODE_PTR  = 3'd4;

    // Operations of the digit unit.
    typedef logic [2:0] t_dig_op;
    localparam t_dig_op OP_HOLD     = 3'd0;
    localparam t_dig_op OP_LOAD_BIN = 3'd1;
    localparam t_dig_op OP_LOAD_HEX = 3'd2;
    localparam t_dig_op OP_DABBLE   = 3'd3;
    localparam t_dig_op OP_SHIFT    = 3'd4;

    typedef struct packed {
        logic [3:0] top_nib;
        logic       cnt_one;
    } t_dig_stat;

    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_X     = 8'h78;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_UA    = 8'h41;

    function automatic logic [7:0] nib_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        if (nib < 4'd10) begin
            base = CHR_ZERO;
        end else begin
            base = (upper ? CHR_UA : CHR_LA) - 8'd10;
        end
        return base + {4'd0, nib};
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2a_digits.sv
// Digit unit: a 64-bit nibble register with load, shift-add-3 step and nibble shift.
// Depends on i2a_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2a_digits
    import i2a_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dig_op            i_op,
    input  wire logic [VALUE_W-1:0] i_load,
    output t_dig_stat               o_stat
);

    localparam int unsigned BCD_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

    logic [LOW_W-1:0]   r_bin,    n_bin;
    logic [VALUE_W-1:0] r_digits, n_digits;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;

    // One binary-to-BCD step: every digit of five or more gets three added,
    // then the whole BCD word shifts left taking in the next binary bit.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    always_comb begin
        n_bin    = r_bin;
        n_digits = r_digits;
        n_cnt    = r_cnt;
        case (i_op)
            OP_LOAD_BIN: begin
                n_bin    = i_load[LOW_W-1:0];
                n_digits = '0;
                n_cnt    = CNT_W'(NIB_CNT);
            end
            OP_LOAD_HEX: begin
                n_digits = i_load;
                n_cnt    = CNT_W'(NIB_CNT);
            end
            OP_DABBLE: begin
                n_bin    = {r_bin[LOW_W-2:0], 1'b0};
                n_digits = {{(VALUE_W-BCD_W){1'b0}},
                            dabble(r_digits[BCD_W-1:0], r_bin[LOW_W-1])};
            end
            OP_SHIFT: begin
                n_digits = {r_digits[VALUE_W-5:0], 4'd0};
                n_cnt    = r_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_digits <= n_digits;
    end

    assign o_stat.top_nib = r_digits[VALUE_W-1 -: 4];
    assign o_stat.cnt_one = (r_cnt == CNT_W'(1));

    `ASSERT_IMP(a_shift_has_digit, i_clk, i_rst_n, i_op == OP_SHIFT, r_cnt != '0)
    `ASSERT_NXT(a_load_full, i_clk, i_rst_n,
        i_op == OP_LOAD_HEX || i_op == OP_LOAD_BIN, r_cnt == CNT_W'(NIB_CNT))
    `ASSERT_NXT(a_dabble_keeps_cnt, i_clk, i_rst_n, i_op == OP_DABBLE, $stable(r_cnt))

endmodule

`default_nettype wire

>>> rtl/integer_to_ascii_radix_top.sv
// Top level of the integer-to-ASCII converter: command port, sequencer, result register.
// Depends on i2a_pkg, i2a_digits and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A value is taken when start is high and busy is low; busy then stays high
// until the last character has been sent. Characters come out most significant
// first, one per cycle, each on o_character for a single cycle with o_valid
// high, and o_last marks the final one; there is no way to hold them off, so
// the receiver must take every character in the cycle it appears. Decimal
// modes first run the shared shift-add-3 unit over all 32 bits of the low word.
// Every mode then drops each leading zero nibble of the 64-bit digit register
// (up to 15), checks the nibble that holds the first digit, and then sends the
// characters (sign, "0x", digits). Mode codes 5 to 7 are taken, leave busy low
// and produce no characters.
module integer_to_ascii_radix_top
    import i2a_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [2:0]         i_mode,
    output logic                    o_valid,
    output logic [7:0]              o_character,
    output logic                    o_last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DABBLE = 3'd1;
    localparam logic [2:0] S_SKIP   = 3'd2;
    localparam logic [2:0] S_MINUS  = 3'd3;
    localparam logic [2:0] S_ZERO   = 3'd4;
    localparam logic [2:0] S_XCHR   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    localparam int unsigned ITER_W = $clog2(LOW_W);

    logic [2:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter,  n_iter;
    logic              r_neg,   n_neg;
    logic              r_ptr,   n_ptr;
    logic              r_upper, n_upper;
    logic              r_valid, n_valid;
    logic              r_last,  n_last;
    logic [7:0]        r_char,  n_char;

    t_dig_op            dig_op;
    logic [VALUE_W-1:0] dig_load;
    t_dig_stat          dig_stat;
    logic               accept;
    logic [LOW_W-1:0]   low;

    i2a_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (dig_op),
        .i_load  (dig_load),
        .o_stat  (dig_stat)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign low    = i_value[LOW_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_neg    = r_neg;
        n_ptr    = r_ptr;
        n_upper  = r_upper;
        dig_op   = OP_HOLD;
        dig_load = i_value;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg   = 1'b0;
                    n_ptr   = 1'b0;
                    n_upper = 1'b0;
                    n_iter  = '0;
                    case (i_mode)
                        MODE_SDEC: begin
                            // The two's complement magnitude of the most negative
                            // value is 2^31, which is exact as unsigned.
                            n_neg    = low[LOW_W-1];
                            dig_load = {{(VALUE_W-LOW_W){1'b0}},
                                        low[LOW_W-1] ? (~low + LOW_W'(1)) : low};
                            dig_op   = OP_LOAD_BIN;
                            n_state  = S_DABBLE;
                        end
                        MODE_UDEC: begin
                            dig_load = {{(VALUE_W-LOW_W){1'b0}}, low};
                            dig_op   = OP_LOAD_BIN;
                            n_state  = S_DABBLE;
                        end
                        MODE_HEXL, MODE_HEXU: begin
                            n_upper  = (i_mode == MODE_HEXU);
                            dig_load = {{(VALUE_W-LOW_W){1'b0}}, low};
                            dig_op   = OP_LOAD_HEX;
                            n_state  = S_SKIP;
                        end
                        MODE_PTR: begin
                            n_ptr   = 1'b1;
                            dig_op  = OP_LOAD_HEX;
                            n_state = S_SKIP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DABBLE: begin
                dig_op = OP_DABBLE;
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(LOW_W - 1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // Drop leading zero nibbles, but always keep one digit.
                if (dig_stat.top_nib == 4'd0 && !dig_stat.cnt_one) begin
                    dig_op = OP_SHIFT;
                end else if (r_neg) begin
                    n_state = S_MINUS;
                end else if (r_ptr) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MINUS: begin
                n_state = S_EMIT;
            end
            S_ZERO: begin
                n_state = S_XCHR;
            end
            S_XCHR: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                dig_op = OP_SHIFT;
                if (dig_stat.cnt_one) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_state inside {S_MINUS, S_ZERO, S_XCHR, S_EMIT};
        n_last  = (r_state == S_EMIT) && dig_stat.cnt_one;
        case (r_state)
            S_MINUS: n_char = CHR_MINUS;
            S_ZERO:  n_char = CHR_ZERO;
            S_XCHR:  n_char = CHR_X;
            default: n_char = nib_char(dig_stat.top_nib, r_upper);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_ptr   <= n_ptr;
        r_upper <= n_upper;
        r_char  <= n_char;
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last && r_valid;

    `ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_last, !o_valid)
    `ASSERT_IMP(a_busy_mid_number, i_clk, i_rst_n, o_valid && !o_last, busy)
    `ASSERT_IMP(a_busy_from_start, i_clk, i_rst_n, $rose(busy), $past(start))

endmodule

`default_nettype wire
